>>> src/cqs_pkg.sv
// ----------------------------------------------------------------------------
// cqs_pkg
// Shared types and constants for the circular queue with search.
// ----------------------------------------------------------------------------
`default_nettype none

package cqs_pkg;

	localparam int unsigned DEPTH = 64;
	localparam int unsigned IDX_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = IDX_W + 1;
	localparam int unsigned VAL_W = 32;

	typedef enum logic [1:0] {
		OP_ENQ  = 2'd0,
		OP_DEQ  = 2'd1,
		OP_FIND = 2'd2,
		OP_LIST = 2'd3
	} cqs_op_t;

	typedef enum logic [2:0] {
		ST_ENQ   = 3'd0,
		ST_OVF   = 3'd1,
		ST_DEQ   = 3'd2,
		ST_UNF   = 3'd3,
		ST_FOUND = 3'd4,
		ST_MISS  = 3'd5,
		ST_ITEM  = 3'd6,
		ST_EMPTY = 3'd7
	} cqs_status_t;

	typedef enum logic [1:0] {
		DSEL_ZERO,
		DSEL_VAL,
		DSEL_RDATA
	} cqs_dsel_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ENQ,
		S_DEQ,
		S_FIND,
		S_LIST
	} cqs_state_t;

	typedef struct packed {
		logic        start;
		logic        off_inc;
		logic        enq_write;
		logic        deq_adv;
		logic        push;
		cqs_status_t push_status;
		cqs_dsel_t   push_dsel;
		logic        push_last;
	} cqs_cmd_t;

	typedef struct packed {
		logic out_free;
		logic full;
		logic empty;
		logic scan_end;
		logic match;
		logic list_last;
	} cqs_stat_t;

endpackage

`default_nettype wire

>>> src/cqs_ctrl.sv
// ----------------------------------------------------------------------------
// cqs_ctrl
// Request sequencer: takes one request, steps the datapath through it.
// ----------------------------------------------------------------------------
`default_nettype none

module cqs_ctrl import cqs_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      s_tvalid,
	input  wire logic [1:0] req_op,
	output logic           s_tready,
	input  wire cqs_stat_t stat,
	output cqs_cmd_t       cmd
);

	cqs_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					case (cqs_op_t'(req_op))
						OP_ENQ:  state_d = S_ENQ;
						OP_DEQ:  state_d = S_DEQ;
						OP_FIND: state_d = S_FIND;
						OP_LIST: state_d = S_LIST;
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_ENQ, S_DEQ: begin
				if (stat.out_free) state_d = S_IDLE;
			end
			S_FIND: begin
				if ((stat.scan_end || stat.match) && stat.out_free) state_d = S_IDLE;
			end
			S_LIST: begin
				if (stat.out_free && (stat.empty || stat.list_last)) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		s_tready        = 1'b0;
		cmd             = '0;
		cmd.push_status = ST_ENQ;
		cmd.push_dsel   = DSEL_ZERO;
		case (state_q)
			S_IDLE: begin
				s_tready  = 1'b1;
				cmd.start = s_tvalid;
			end
			S_ENQ: begin
				cmd.push      = stat.out_free;
				cmd.push_last = 1'b1;
				if (stat.full) begin
					cmd.push_status = ST_OVF;
				end else begin
					cmd.enq_write   = stat.out_free;
					cmd.push_status = ST_ENQ;
					cmd.push_dsel   = DSEL_VAL;
				end
			end
			S_DEQ: begin
				cmd.push      = stat.out_free;
				cmd.push_last = 1'b1;
				if (stat.empty) begin
					cmd.push_status = ST_UNF;
				end else begin
					cmd.deq_adv     = stat.out_free;
					cmd.push_status = ST_DEQ;
					cmd.push_dsel   = DSEL_RDATA;
				end
			end
			S_FIND: begin
				cmd.push_dsel = DSEL_VAL;
				cmd.push_last = 1'b1;
				if (stat.scan_end || stat.match) begin
					cmd.push        = stat.out_free;
					cmd.push_status = (!stat.scan_end && stat.match) ? ST_FOUND : ST_MISS;
				end else begin
					cmd.off_inc = 1'b1;
				end
			end
			S_LIST: begin
				cmd.push = stat.out_free;
				if (stat.empty) begin
					cmd.push_status = ST_EMPTY;
					cmd.push_last   = 1'b1;
				end else begin
					cmd.push_status = ST_ITEM;
					cmd.push_dsel   = DSEL_RDATA;
					cmd.push_last   = stat.list_last;
					cmd.off_inc     = stat.out_free;
				end
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> src/cqs_dp.sv
// ----------------------------------------------------------------------------
// cqs_dp
// Datapath: slot memory, head/count/capacity, scan offset, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cqs_dp import cqs_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_wen,
	input  wire logic [CNT_W-1:0]  cfg_wdata,
	input  wire logic [VAL_W-1:0]  req_value,
	input  wire cqs_cmd_t          cmd,
	output cqs_stat_t              stat,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [VAL_W-1:0]       m_tdata,
	output logic [2:0]             m_tuser,
	output logic                   m_tlast
);

	logic [VAL_W-1:0] mem [DEPTH];

	logic [CNT_W-1:0] cap_q;
	logic [IDX_W-1:0] head_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] off_q;
	logic [VAL_W-1:0] val_q;
	logic [VAL_W-1:0] rdata_q;

	logic             ovld_q;
	logic [VAL_W-1:0] odata_q;
	cqs_status_t      ostat_q;
	logic             olast_q;

	logic [CNT_W-1:0] size;
	logic [CNT_W-1:0] off_d;
	logic [CNT_W-1:0] rsum, wsum, hsum;
	logic [IDX_W-1:0] raddr, waddr, head_nx;
	logic [VAL_W-1:0] push_data;

	// ring size: zero acts as one, above DEPTH acts as DEPTH
	always_comb begin
		if (cap_q == '0) begin
			size = CNT_W'(1);
		end else if (cap_q > CNT_W'(DEPTH)) begin
			size = CNT_W'(DEPTH);
		end else begin
			size = cap_q;
		end
	end

	always_comb begin
		if (cmd.start) begin
			off_d = '0;
		end else if (cmd.off_inc) begin
			off_d = off_q + CNT_W'(1);
		end else begin
			off_d = off_q;
		end
	end

	// read one offset ahead so rdata_q always matches off_q
	always_comb begin
		rsum  = CNT_W'(head_q) + off_d;
		if (rsum >= size) rsum = rsum - size;
		raddr = rsum[IDX_W-1:0];
		wsum  = CNT_W'(head_q) + count_q;
		if (wsum >= size) wsum = wsum - size;
		waddr = wsum[IDX_W-1:0];
		hsum  = CNT_W'(head_q) + CNT_W'(1);
		if (hsum >= size) hsum = '0;
		head_nx = hsum[IDX_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.enq_write) begin
			mem[waddr] <= val_q;
		end
		rdata_q <= mem[raddr];
		if (cmd.start) begin
			val_q <= req_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= CNT_W'(DEPTH);
			head_q  <= '0;
			count_q <= '0;
			off_q   <= '0;
		end else begin
			off_q <= off_d;
			if (cfg_wen) begin
				cap_q   <= cfg_wdata;
				head_q  <= '0;
				count_q <= '0;
			end else if (cmd.enq_write) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cmd.deq_adv) begin
				head_q  <= head_nx;
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_comb begin
		case (cmd.push_dsel)
			DSEL_VAL:   push_data = val_q;
			DSEL_RDATA: push_data = rdata_q;
			default:    push_data = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovld_q <= 1'b0;
		end else if (cmd.push) begin
			ovld_q <= 1'b1;
		end else if (m_tready) begin
			ovld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			odata_q <= push_data;
			ostat_q <= cmd.push_status;
			olast_q <= cmd.push_last;
		end
	end

	assign stat.out_free  = !ovld_q || m_tready;
	assign stat.full      = (count_q >= size);
	assign stat.empty     = (count_q == '0);
	assign stat.scan_end  = (off_q >= count_q);
	assign stat.match     = (rdata_q == val_q);
	assign stat.list_last = ((off_q + CNT_W'(1)) == count_q);

	assign m_tvalid = ovld_q;
	assign m_tdata  = odata_q;
	assign m_tuser  = ostat_q;
	assign m_tlast  = olast_q;

endmodule

`default_nettype wire

>>> src/circular_queue_with_search.sv
// ----------------------------------------------------------------------------
// circular_queue_with_search
// Ring-buffer FIFO of configurable capacity with enqueue, dequeue, find, list.
// ----------------------------------------------------------------------------
//  channel  | signals                          | contents
//  ---------+----------------------------------+---------------------------------
//  request  | s_tvalid s_tready s_tdata s_tuser| tuser[1:0] opcode, tdata value
//  result   | m_tvalid m_tready m_tdata m_tuser| tuser[2:0] status, tdata data,
//           | m_tlast                          | tlast last result of a request
//  config   | cfg_wen cfg_wdata                | [6:0] capacity (empties queue)
//
//  One request at a time: the idle state takes it, enqueue and dequeue give
//  one result each, find compares entries from the head until a match or the
//  last entry, and list emits every entry in order; the single read port of
//  the slot memory sets the pace. A result waits in an output register; a
//  stalled m_tready holds the sequencer. After reset the queue is empty with
//  capacity 64; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_queue_with_search import cqs_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_wen,
	input  wire logic [CNT_W-1:0] cfg_wdata,  // [6:0] capacity
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	input  wire logic [VAL_W-1:0] s_tdata,    // [31:0] value
	input  wire logic [1:0]       s_tuser,    // [1:0] opcode
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic [VAL_W-1:0]      m_tdata,    // [31:0] data
	output logic [2:0]            m_tuser,    // [2:0] status
	output logic                  m_tlast
);

	cqs_cmd_t  cmd;
	cqs_stat_t stat;

	cqs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.req_op   (s_tuser),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	cqs_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.req_value (s_tdata),
		.cmd       (cmd),
		.stat      (stat),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

`default_nettype wire

>>> test/tb_circular_queue_with_search.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_circular_queue_with_search
// Self-checking bench for the ring-buffer queue with find and list.
// A short table of directed requests covers empty and full queues, extreme
// values and capacity rewrites. It is followed by random segments at several
// capacities under three idle patterns. Every result transfer is compared
// with the table's expected result or with a behavioral queue model kept in
// step at each request transfer.

module tb_circular_queue_with_search;
	import cqs_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;

	typedef struct {
		cqs_status_t      status;
		logic [VAL_W-1:0] data;
		logic             last;
	} response_t;

	typedef struct {
		bit               is_cfg;
		cqs_op_t          op;
		logic [VAL_W-1:0] val;
		bit               typed;
		cqs_status_t      status;
		logic [VAL_W-1:0] data;
	} step_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_wen = 1'b0;
	logic [CNT_W-1:0] cfg_wdata = '0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [VAL_W-1:0] s_tdata = '0;   // [31:0] value
	logic [1:0]       s_tuser = '0;   // [1:0] opcode
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [VAL_W-1:0] m_tdata;        // [31:0] data
	logic [2:0]       m_tuser;        // [2:0] status
	logic             m_tlast;

	circular_queue_with_search dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	// queue model
	logic [VAL_W-1:0] ring [DEPTH];
	int unsigned      head = 0;
	int unsigned      count = 0;
	logic [CNT_W-1:0] cap_reg = 7'd64;

	response_t responses_due [$];
	response_t model_out [$];
	response_t due;
	step_t     steps [$];

	int  errors = 0;
	int  tx_idle_pct = 21;
	int  rx_idle_pct = 48;
	int  idle_cycles = 0;
	bit  tx_low = 1'b1;

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic int unsigned ring_size();
		int unsigned c;
		c = 32'(cap_reg);
		if (c == 0) c = 1;
		if (c > DEPTH) c = DEPTH;
		return c;
	endfunction

	function automatic void predict_response(cqs_op_t op, logic [VAL_W-1:0] val);
		int unsigned size;
		bit          hit;
		size = ring_size();
		hit = 1'b0;
		model_out.delete();
		if (head >= size) head = 0;
		if (count > size) count = size;
		case (op)
			OP_ENQ: begin
				if (count < size) begin
					ring[(head + count) % size] = val;
					count++;
					model_out.push_back('{ST_ENQ, val, 1'b1});
				end else begin
					model_out.push_back('{ST_OVF, '0, 1'b1});
				end
			end
			OP_DEQ: begin
				if (count != 0) begin
					model_out.push_back('{ST_DEQ, ring[head], 1'b1});
					head = (head + 1) % size;
					count--;
				end else begin
					model_out.push_back('{ST_UNF, '0, 1'b1});
				end
			end
			OP_FIND: begin
				for (int unsigned i = 0; i < count; i++)
					if (ring[(head + i) % size] == val) hit = 1'b1;
				model_out.push_back('{hit ? ST_FOUND : ST_MISS, val, 1'b1});
			end
			default: begin
				if (count == 0)
					model_out.push_back('{ST_EMPTY, '0, 1'b1});
				for (int unsigned i = 0; i < count; i++)
					model_out.push_back('{ST_ITEM, ring[(head + i) % size], i + 1 == count});
			end
		endcase
	endfunction

	task automatic stop_tx();
		if (!tx_low) begin
			s_tvalid <= 1'b0;
			tx_low = 1'b1;
		end
	endtask

	task automatic wait_settled();
		stop_tx();
		while (responses_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_capacity(logic [CNT_W-1:0] cap);
		wait_settled();
		cfg_wen <= 1'b1;
		cfg_wdata <= cap;
		@(posedge clk);
		cfg_wen <= 1'b0;
		cap_reg = cap;
		head = 0;
		count = 0;
	endtask

	task automatic issue(step_t row);
		while ($urandom_range(99) < tx_idle_pct) begin
			stop_tx();
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		tx_low = 1'b0;
		s_tdata <= row.val;
		s_tuser <= row.op;
		do @(posedge clk); while (!s_tready);
		predict_response(row.op, row.val);
		if (row.typed)
			responses_due.push_back('{row.status, row.data, 1'b1});
		else
			foreach (model_out[k]) responses_due.push_back(model_out[k]);
	endtask

	function automatic logic [VAL_W-1:0] pick_value();
		case ($urandom_range(7))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0000_0000;
			3: return 32'hFFFF_FFFF;
			4, 5: return $urandom_range(15);
			default: return $urandom;
		endcase
	endfunction

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= rx_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (responses_due.size() == 0) begin
				$display("%0t: unexpected transfer, expected none, actual status %0d data %h",
					$time, m_tuser, m_tdata);
				errors++;
			end else begin
				due = responses_due.pop_front();
				if (m_tuser !== due.status) begin
					$display("%0t: status mismatch, expected %0d, actual %0d",
						$time, due.status, m_tuser);
					errors++;
				end
				if (m_tdata !== due.data) begin
					$display("%0t: data mismatch, expected %h, actual %h",
						$time, due.data, m_tdata);
					errors++;
				end
				if (m_tlast !== due.last) begin
					$display("%0t: last mismatch, expected %b, actual %b",
						$time, due.last, m_tlast);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || cfg_wen || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		step_t            row;
		int unsigned      n_items;
		int unsigned      enq_pct;
		int unsigned      r;
		logic [CNT_W-1:0] cap;
		cqs_op_t          op;
		logic [VAL_W-1:0] val;

		steps.push_back('{1'b0, OP_DEQ,  32'h0000_0000, 1'b1, ST_UNF,   32'h0000_0000});
		steps.push_back('{1'b0, OP_LIST, 32'hFFFF_FFFF, 1'b1, ST_EMPTY, 32'h0000_0000});
		steps.push_back('{1'b0, OP_FIND, 32'h1234_5678, 1'b1, ST_MISS,  32'h1234_5678});
		steps.push_back('{1'b0, OP_ENQ,  32'h8000_0000, 1'b1, ST_ENQ,   32'h8000_0000});
		steps.push_back('{1'b0, OP_ENQ,  32'h7FFF_FFFF, 1'b1, ST_ENQ,   32'h7FFF_FFFF});
		steps.push_back('{1'b0, OP_ENQ,  32'hFFFF_FFFF, 1'b1, ST_ENQ,   32'hFFFF_FFFF});
		steps.push_back('{1'b0, OP_ENQ,  32'h0000_0000, 1'b1, ST_ENQ,   32'h0000_0000});
		steps.push_back('{1'b0, OP_FIND, 32'h7FFF_FFFF, 1'b0, ST_ENQ,   32'h0});
		steps.push_back('{1'b0, OP_FIND, 32'h0000_0001, 1'b0, ST_ENQ,   32'h0});
		steps.push_back('{1'b0, OP_LIST, 32'h0000_0000, 1'b0, ST_ENQ,   32'h0});
		steps.push_back('{1'b0, OP_DEQ,  32'hFFFF_FFFF, 1'b0, ST_ENQ,   32'h0});
		steps.push_back('{1'b0, OP_FIND, 32'h8000_0000, 1'b0, ST_ENQ,   32'h0});
		// capacity 1: full after one entry
		steps.push_back('{1'b1, OP_ENQ,  32'd1,         1'b0, ST_ENQ,   32'h0});
		steps.push_back('{1'b0, OP_ENQ,  32'h0000_002A, 1'b1, ST_ENQ,   32'h0000_002A});
		steps.push_back('{1'b0, OP_ENQ,  32'h5555_5555, 1'b1, ST_OVF,   32'h0000_0000});
		steps.push_back('{1'b0, OP_LIST, 32'h0000_0000, 1'b0, ST_ENQ,   32'h0});
		steps.push_back('{1'b0, OP_DEQ,  32'h0000_0000, 1'b1, ST_DEQ,   32'h0000_002A});
		steps.push_back('{1'b0, OP_DEQ,  32'h0000_0000, 1'b1, ST_UNF,   32'h0000_0000});
		// capacity 0 acts as 1
		steps.push_back('{1'b1, OP_ENQ,  32'd0,         1'b0, ST_ENQ,   32'h0});
		steps.push_back('{1'b0, OP_ENQ,  32'hAAAA_AAAA, 1'b1, ST_ENQ,   32'hAAAA_AAAA});
		steps.push_back('{1'b0, OP_ENQ,  32'h0000_0001, 1'b1, ST_OVF,   32'h0000_0000});
		// capacity above DEPTH acts as DEPTH; the write empties the queue
		steps.push_back('{1'b1, OP_ENQ,  32'd127,       1'b0, ST_ENQ,   32'h0});
		steps.push_back('{1'b0, OP_LIST, 32'h0000_0000, 1'b1, ST_EMPTY, 32'h0000_0000});
		steps.push_back('{1'b0, OP_ENQ,  32'h0000_0001, 1'b0, ST_ENQ,   32'h0});
		steps.push_back('{1'b0, OP_FIND, 32'h0000_0001, 1'b0, ST_ENQ,   32'h0});

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (steps[i]) begin
			row = steps[i];
			if (row.is_cfg)
				set_capacity(row.val[CNT_W-1:0]);
			else
				issue(row);
		end

		for (int mode = 0; mode < 3; mode++) begin
			case (mode)
				0: begin tx_idle_pct = 21; rx_idle_pct = 48; end
				1: begin tx_idle_pct = 48; rx_idle_pct = 21; end
				default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
			endcase
			for (int seg = 0; seg < 3; seg++) begin
				case (seg)
					0: begin cap = 7'd64; n_items = 70; enq_pct = 75; end
					1: begin
						cap = CNT_W'($urandom_range(2, 8));
						n_items = 40;
						enq_pct = $urandom_range(35, 60);
					end
					default: begin
						cap = CNT_W'($urandom_range(127));
						n_items = 40;
						enq_pct = $urandom_range(30, 60);
					end
				endcase
				set_capacity(cap);
				for (int n = 0; n < n_items; n++) begin
					r = $urandom_range(99);
					if (r < enq_pct) begin
						op = OP_ENQ;
					end else begin
						r = $urandom_range(99);
						op = (r < 50) ? OP_DEQ : (r < 85) ? OP_FIND : OP_LIST;
					end
					val = (op == OP_ENQ || op == OP_FIND) ? pick_value() : $urandom;
					if (op == OP_FIND && count != 0 && $urandom_range(1))
						val = ring[(head + $urandom_range(count - 1)) % ring_size()];
					if ($urandom_range(49) == 0)
						wait_settled();
					issue('{1'b0, op, val, 1'b0, ST_ENQ, '0});
				end
			end
		end

		wait_settled();
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
